>>> hw/rtl/drl_pkg.sv
// ----------------------------------------------------------------------------
// drl_pkg
// Shared types and constants of the destination rate limited port rewriter:
// frame length limits, protocol codes, result codes, register indexes and
// the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package drl_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;

    localparam int IN_DATA_W  = 136;
    localparam int OUT_DATA_W = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [63:0] HOLD_RESET = 64'd10000000000;

    localparam logic [15:0] ETH_HDR_BYTES  = 16'd14;
    localparam logic [15:0] IP_END_BYTES   = 16'd34;
    localparam logic [15:0] UDP_END_BYTES  = 16'd42;
    localparam logic [15:0] TCP_END_BYTES  = 16'd54;
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;

    localparam logic [2:0] EV_NONE       = 3'd0;
    localparam logic [2:0] EV_SUPPRESSED = 3'd1;
    localparam logic [2:0] EV_INSERTED   = 3'd2;
    localparam logic [2:0] EV_REFRESHED  = 3'd3;
    localparam logic [2:0] EV_FULL       = 3'd4;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_UDP  = 2'd1;
    localparam logic [1:0] KIND_TCP  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEW_DEST_PORT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEW_SRC_PORT  = 2'd2;

    // Controller to datapath.
    typedef struct packed {
        logic       load_in;
        logic       scan_start;
        logic       scan_next;
        logic       write_time;
        logic       insert;
        logic       set_res;
        logic [2:0] ev;
        logic       load_out;
    } t_drl_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic early;
        logic cnt_zero;
        logic full;
        logic hit;
        logic elapsed_gt;
        logic last;
        logic out_free;
    } t_drl_sts;

endpackage

>>> hw/rtl/drl_ctrl.sv
// ----------------------------------------------------------------------------
// drl_ctrl
// Sequencer of the rate limiter: takes a request, classifies it, walks the
// filled part of the destination table one slot per cycle and hands the
// result to the output register.
// ----------------------------------------------------------------------------
module drl_ctrl import drl_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_axis_tvalid,
    output logic     o_s_axis_tready,
    input  t_drl_sts i_sts,
    output t_drl_cmd o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CLASS = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_s_axis_tready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.ev = EV_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_CLASS;
                end
            end
            S_CLASS: begin
                if (i_sts.early) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.ev = EV_NONE;
                    n_state = S_DONE;
                end else if (i_sts.cnt_zero) begin
                    o_cmd.insert = 1'b1;
                    o_cmd.set_res = 1'b1;
                    o_cmd.ev = EV_INSERTED;
                    n_state = S_DONE;
                end else begin
                    o_cmd.scan_start = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.hit) begin
                    o_cmd.set_res = 1'b1;
                    if (i_sts.elapsed_gt) begin
                        o_cmd.write_time = 1'b1;
                        o_cmd.ev = EV_REFRESHED;
                    end else begin
                        o_cmd.ev = EV_SUPPRESSED;
                    end
                    n_state = S_DONE;
                end else if (i_sts.last) begin
                    o_cmd.set_res = 1'b1;
                    if (i_sts.full) begin
                        o_cmd.ev = EV_FULL;
                    end else begin
                        o_cmd.insert = 1'b1;
                        o_cmd.ev = EV_INSERTED;
                    end
                    n_state = S_DONE;
                end else begin
                    o_cmd.scan_next = 1'b1;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> hw/rtl/drl_dp.sv
// ----------------------------------------------------------------------------
// drl_dp
// Datapath of the rate limiter: request registers, destination table
// memories with a fill count, slot compare and elapsed time check, result
// encoding, output register and configuration registers.
// ----------------------------------------------------------------------------
module drl_dp import drl_pkg::*; #(
    parameter int ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_drl_cmd              i_cmd,
    output t_drl_sts              o_sts
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    logic [15:0] r_len;
    logic [15:0] r_etype;
    logic [7:0]  r_proto;
    logic [31:0] r_key;
    logic [63:0] r_now;
    logic [63:0] r_hold;

    logic [31:0] r_addr_mem [ENTRIES];
    logic [63:0] r_time_mem [ENTRIES];
    logic [31:0] r_addr_q;
    logic [63:0] r_time_q;

    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    logic [IDX_W-1:0] wr_idx;
    logic [CNT_W-1:0] r_count;

    logic       r_res_verdict;
    logic [1:0] r_res_kind;
    logic [2:0] r_res_event;
    logic       n_verdict;
    logic [1:0] n_kind;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic        is_ip;
    logic        early_drop;
    logic [63:0] elapsed;

    assign is_ip      = (r_etype == ETHERTYPE_IPV4);
    assign early_drop = (r_len < ETH_HDR_BYTES) || (is_ip && (r_len < IP_END_BYTES));
    assign elapsed    = r_now - r_time_q;

    assign o_sts.early      = early_drop || !is_ip;
    assign o_sts.cnt_zero   = (r_count == '0);
    assign o_sts.full       = (r_count == CNT_W'(ENTRIES));
    assign o_sts.hit        = (r_addr_q == r_key);
    assign o_sts.elapsed_gt = (elapsed > r_hold);
    assign o_sts.last       = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);
    assign o_sts.out_free   = !r_out_valid || i_m_axis_tready;

    // The read index runs one step ahead so that the registered read data
    // always belongs to the slot held in r_idx.
    always_comb begin
        if (i_cmd.scan_start) begin
            n_idx = '0;
        end else if (i_cmd.scan_next) begin
            n_idx = r_idx + IDX_W'(1);
        end else begin
            n_idx = r_idx;
        end
    end

    assign wr_idx = i_cmd.insert ? r_count[IDX_W-1:0] : r_idx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.insert) begin
            r_addr_mem[wr_idx] <= r_key;
        end
        if (i_cmd.insert || i_cmd.write_time) begin
            r_time_mem[wr_idx] <= r_now;
        end
        r_addr_q <= r_addr_mem[n_idx];
        r_time_q <= r_time_mem[n_idx];
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_cmd.load_in) begin
            r_len   <= i_s_axis_tdata[15:0];
            r_etype <= i_s_axis_tdata[31:16];
            r_proto <= i_s_axis_tdata[39:32];
            r_key   <= i_s_axis_tdata[71:40];
            r_now   <= i_s_axis_tdata[135:72];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.insert) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    // Sampled packets get their transport length checked; suppressed ones
    // and early outcomes never carry a rewrite.
    always_comb begin
        n_verdict = 1'b0;
        n_kind    = KIND_NONE;
        case (i_cmd.ev)
            EV_NONE: begin
                n_verdict = early_drop;
            end
            EV_SUPPRESSED: begin
                n_verdict = 1'b0;
            end
            default: begin
                if (r_proto == PROTO_UDP) begin
                    if (r_len < UDP_END_BYTES) begin
                        n_verdict = 1'b1;
                    end else begin
                        n_kind = KIND_UDP;
                    end
                end else if (r_proto == PROTO_TCP) begin
                    if (r_len < TCP_END_BYTES) begin
                        n_verdict = 1'b1;
                    end else begin
                        n_kind = KIND_TCP;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.set_res) begin
            r_res_verdict <= n_verdict;
            r_res_kind    <= n_kind;
            r_res_event   <= i_cmd.ev;
        end
        if (i_cmd.load_out) begin
            r_out_data <= {2'b00, r_res_event, r_res_kind, r_res_verdict};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_cfg_ready     = 1'b1;

    // The port values do not affect any result of this block, so their
    // writes are taken and discarded.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= HOLD_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_HOLD_INTERVAL: r_hold <= i_cfg_data;
                CFG_NEW_DEST_PORT: begin
                end
                CFG_NEW_SRC_PORT: begin
                end
                default: begin
                end
            endcase
        end
    end

endmodule

>>> hw/rtl/dest_rate_limited_port_rewriter.sv
// ----------------------------------------------------------------------------
// dest_rate_limited_port_rewriter
// Per destination rate limiter: classifies parsed frame summaries, samples
// each IPv4 destination at most once per hold interval and flags sampled
// UDP and TCP packets for port rewrite.
//
//   channel  direction  handshake                        payload
//   s_axis   in         i_s_axis_tvalid/o_s_axis_tready  136 bit frame summary
//   m_axis   out        o_m_axis_tvalid/i_m_axis_tready  8 bit result
//   cfg      in         i_cfg_valid/o_cfg_ready          2 bit index, 64 bit data
//
// A request needs no table walk on an early outcome or an empty table;
// otherwise the walk reads the slots up to and including the hit, or the
// whole fill count on a miss.
// The table walk reads one slot per cycle.
// Reset clears the fill count and loads the register defaults; no clearing
// pass is needed. A stalled output holds the result and the next request
// is still taken, waiting only to hand over its own result.
// ----------------------------------------------------------------------------
module dest_rate_limited_port_rewriter import drl_pkg::*; #(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // [15:0] frame_length, [31:16] ether_type, [39:32] ip_protocol,
    // [71:40] dest_ip, [135:72] now_ns
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [0] verdict, [2:1] rewrite_kind, [5:3] table_event, [7:6] zero
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_drl_cmd cmd;
    t_drl_sts sts;

    drl_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_sts           (sts),
        .o_cmd           (cmd)
    );

    drl_dp #(
        .ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (cmd),
        .o_sts           (sts)
    );

endmodule

>>> hw/rtl/drl_checker.sv
// ----------------------------------------------------------------------------
// drl_checker
// Port level checks of the rate limiter: output stability under stall and
// consistency of the result codes.
// ----------------------------------------------------------------------------
module drl_checker import drl_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    a_drop_no_rewrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[0] |-> o_m_axis_tdata[2:1] == KIND_NONE)
        else $error("dropped packet marked for rewrite");

    a_codes_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[2:1] != 2'd3 && o_m_axis_tdata[5:3] <= EV_FULL
            && o_m_axis_tdata[7:6] == 2'b00)
        else $error("illegal result code");

    a_suppressed_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[5:3] == EV_SUPPRESSED |->
            o_m_axis_tdata[2:0] == 3'b000)
        else $error("suppressed packet not passed untouched");

    a_no_lookup_no_rewrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[5:3] == EV_NONE |->
            o_m_axis_tdata[2:1] == KIND_NONE)
        else $error("rewrite without table lookup");

endmodule

bind dest_rate_limited_port_rewriter drl_checker u_drl_checker (.*);

>>> test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the destination rate limited port rewriter. Frame
// summaries go in on the slave stream and verdicts come back on the master
// stream. A behavioral copy of the destination table predicts every verdict.
// Directed frames cover the length, type and protocol boundaries, the hold
// interval edge and time wrap. Random phases then run under several register
// settings, with random stalls on both streams. The last phase fills the
// table until it overflows.
// ----------------------------------------------------------------------------
module tb_top import drl_pkg::*; ();

    localparam int POOL_SIZE      = 40;
    localparam int SETTLE_CYCLES  = TABLE_ENTRIES_DEF + 16;
    localparam int WATCHDOG_LIMIT = 4000;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED     = 2'd3;
    localparam logic [63:0]          HOLD_MAX       = '1;
    localparam logic [15:0]          ETHERTYPE_IPV6 = 16'h86DD;

    // First field in the lowest bits, as on the slave stream.
    typedef struct packed {
        logic [63:0] now_ns;
        logic [31:0] dest_ip;
        logic [7:0]  ip_protocol;
        logic [15:0] ether_type;
        logic [15:0] frame_length;
    } t_frame_summary;

    typedef struct packed {
        logic [1:0] pad;
        logic [2:0] table_event;
        logic [1:0] rewrite_kind;
        logic       verdict;
    } t_verdict;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Predictor state: destination table and hold interval copy.
    logic        dest_used [TABLE_ENTRIES_DEF];
    logic [31:0] dest_addr [TABLE_ENTRIES_DEF];
    logic [63:0] dest_stamp[TABLE_ENTRIES_DEF];
    logic [63:0] hold_ns = HOLD_RESET;

    t_verdict    expected_verdicts[$];
    logic [31:0] dest_pool[POOL_SIZE];
    logic [63:0] clock_ns = 64'd1000;
    bit          src_idling = 1'b1;
    bit          sink_idling = 1'b1;
    int          errors = 0;
    int          quiet_cycles = 0;

    always #4 i_clk = ~i_clk;

    dest_rate_limited_port_rewriter u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    function automatic t_verdict predict_verdict(input t_frame_summary f);
        t_verdict    v;
        int          hit_slot;
        int          free_slot;
        logic [2:0]  ev;
        logic [63:0] elapsed;
        v = '0;
        hit_slot = -1;
        free_slot = -1;
        if (f.frame_length < ETH_HDR_BYTES) begin
            v.verdict = 1'b1;
            return v;
        end
        if (f.ether_type != ETHERTYPE_IPV4)
            return v;
        if (f.frame_length < IP_END_BYTES) begin
            v.verdict = 1'b1;
            return v;
        end
        for (int i = 0; i < TABLE_ENTRIES_DEF; i++) begin
            if (dest_used[i]) begin
                if (hit_slot < 0 && dest_addr[i] == f.dest_ip)
                    hit_slot = i;
            end else if (free_slot < 0) begin
                free_slot = i;
            end
        end
        if (hit_slot >= 0) begin
            elapsed = f.now_ns - dest_stamp[hit_slot];
            if (elapsed > hold_ns) begin
                dest_stamp[hit_slot] = f.now_ns;
                ev = EV_REFRESHED;
            end else begin
                v.table_event = EV_SUPPRESSED;
                return v;
            end
        end else if (free_slot >= 0) begin
            dest_used[free_slot] = 1'b1;
            dest_addr[free_slot] = f.dest_ip;
            dest_stamp[free_slot] = f.now_ns;
            ev = EV_INSERTED;
        end else begin
            ev = EV_FULL;
        end
        v.table_event = ev;
        // A sampled packet still needs a complete transport header to be rewritten.
        if (f.ip_protocol == PROTO_UDP) begin
            if (f.frame_length < UDP_END_BYTES)
                v.verdict = 1'b1;
            else
                v.rewrite_kind = KIND_UDP;
        end else if (f.ip_protocol == PROTO_TCP) begin
            if (f.frame_length < TCP_END_BYTES)
                v.verdict = 1'b1;
            else
                v.rewrite_kind = KIND_TCP;
        end
        return v;
    endfunction

    task automatic send_summary(input t_frame_summary f);
        int gap;
        gap = src_idling ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= f;
        do @(posedge i_clk); while (!o_s_axis_tready);
        expected_verdicts.push_back(predict_verdict(f));
    endtask

    task automatic send_frame(input logic [15:0] len, input logic [15:0] etype,
                              input logic [7:0] proto, input logic [31:0] dest,
                              input logic [63:0] now);
        t_frame_summary f;
        f.frame_length = len;
        f.ether_type   = etype;
        f.ip_protocol  = proto;
        f.dest_ip      = dest;
        f.now_ns       = now;
        send_summary(f);
    endtask

    task automatic send_random_frame(input logic [63:0] now, input bit fresh_dest);
        t_frame_summary f;
        f.now_ns     = now;
        f.dest_ip    = fresh_dest ? $urandom : dest_pool[$urandom_range(0, POOL_SIZE - 1)];
        f.ether_type = ETHERTYPE_IPV4;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: f.ip_protocol = PROTO_UDP;
            4, 5, 6, 7: f.ip_protocol = PROTO_TCP;
            default:    f.ip_protocol = 8'($urandom_range(0, 255));
        endcase
        case ($urandom_range(0, 9))
            0:       f.frame_length = 16'($urandom_range(IP_END_BYTES, TCP_END_BYTES - 1));
            1:       f.frame_length = UDP_END_BYTES - 16'd1;
            2:       f.frame_length = UDP_END_BYTES;
            3:       f.frame_length = TCP_END_BYTES - 16'd1;
            4:       f.frame_length = TCP_END_BYTES;
            5:       f.frame_length = 16'hFFFF;
            6:       f.frame_length = IP_END_BYTES;
            default: f.frame_length = 16'($urandom_range(TCP_END_BYTES, 1518));
        endcase
        // Broken or foreign frames; a pool address is kept wherever the frame
        // would reach the table, so the table does not fill up early.
        if ($urandom_range(0, 4) == 0) begin
            f.frame_length = ($urandom_range(0, 3) == 0)
                             ? 16'($urandom)
                             : 16'($urandom_range(0, IP_END_BYTES - 1));
            f.ether_type   = $urandom_range(0, 1) ? ETHERTYPE_IPV4 : 16'($urandom);
            f.ip_protocol  = 8'($urandom);
            f.dest_ip      = $urandom;
            if (!fresh_dest && f.ether_type == ETHERTYPE_IPV4 && f.frame_length >= IP_END_BYTES)
                f.dest_ip = dest_pool[$urandom_range(0, POOL_SIZE - 1)];
        end
        send_summary(f);
    endtask

    // Time mostly runs forward in random steps; some frames carry a time far
    // off or slightly in the past.
    task automatic send_batch(input int count, input logic [63:0] step_max,
                              input int wild_pct, input int fresh_pct);
        logic [63:0] now;
        for (int n = 0; n < count; n++) begin
            if (n % 64 == 0) begin
                src_idling  = $urandom_range(0, 3) != 0;
                sink_idling = $urandom_range(0, 3) != 0;
            end
            clock_ns += {$urandom, $urandom} % (step_max + 64'd1);
            now = clock_ns;
            if ($urandom_range(0, 99) < wild_pct)
                now = $urandom_range(0, 1) ? {$urandom, $urandom}
                                           : clock_ns - 64'($urandom_range(1, 1000));
            send_random_frame(now, $urandom_range(0, 99) < fresh_pct);
        end
    endtask

    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        while (expected_verdicts.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        // Only the hold interval shows in the results.
        if (idx == CFG_HOLD_INTERVAL)
            hold_ns = data;
    endtask

    task automatic load_settings(input logic [63:0] hold, input logic [15:0] dport,
                                 input logic [15:0] sport);
        drain_results();
        // No table walk is left running once the last result has left.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_reg(CFG_NEW_DEST_PORT, {$urandom, 16'($urandom), dport});
        write_reg(CFG_NEW_SRC_PORT, {$urandom, 16'($urandom), sport});
        write_reg(CFG_HOLD_INTERVAL, hold);
        // A write past the last register must leave everything unchanged.
        write_reg(CFG_UNUSED, {$urandom, $urandom});
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_directed();
        logic [63:0] t0;
        t0 = 64'd5000;
        send_frame(16'd0, ETHERTYPE_IPV4, PROTO_UDP, dest_pool[0], t0);
        send_frame(ETH_HDR_BYTES - 16'd1, ETHERTYPE_IPV4, PROTO_TCP, dest_pool[0], t0);
        send_frame(ETH_HDR_BYTES, ETHERTYPE_IPV6, PROTO_UDP, dest_pool[0], t0);
        send_frame(16'hFFFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, '1);
        send_frame(16'd100, 16'h0801, PROTO_UDP, dest_pool[0], t0);
        send_frame(ETH_HDR_BYTES, ETHERTYPE_IPV4, PROTO_UDP, dest_pool[0], t0);
        send_frame(IP_END_BYTES - 16'd1, ETHERTYPE_IPV4, PROTO_TCP, dest_pool[0], t0);
        // Frames across the transport length limits, mostly to new destinations.
        send_frame(IP_END_BYTES, ETHERTYPE_IPV4, PROTO_UDP, dest_pool[0], t0);
        send_frame(UDP_END_BYTES - 16'd1, ETHERTYPE_IPV4, PROTO_UDP, dest_pool[0], t0);
        send_frame(UDP_END_BYTES, ETHERTYPE_IPV4, PROTO_UDP, dest_pool[1], t0);
        send_frame(TCP_END_BYTES - 16'd1, ETHERTYPE_IPV4, PROTO_TCP, dest_pool[2], t0);
        send_frame(TCP_END_BYTES, ETHERTYPE_IPV4, PROTO_TCP, dest_pool[3], t0);
        send_frame(16'hFFFF, ETHERTYPE_IPV4, 8'hFF, dest_pool[4], t0);
        send_frame(16'd100, ETHERTYPE_IPV4, 8'h00, dest_pool[5], t0);
        // Exactly one hold interval later is still inside the interval.
        send_frame(16'd100, ETHERTYPE_IPV4, PROTO_UDP, dest_pool[0], t0 + HOLD_RESET);
        send_frame(16'd100, ETHERTYPE_IPV4, PROTO_UDP, dest_pool[0], t0 + HOLD_RESET + 1);
        send_frame(UDP_END_BYTES - 16'd1, ETHERTYPE_IPV4, PROTO_UDP, dest_pool[0],
                   t0 + 2 * HOLD_RESET + 2);
        // Elapsed time across the 64-bit wrap.
        send_frame(16'd60, ETHERTYPE_IPV4, PROTO_TCP, dest_pool[6], HOLD_MAX - 64'd15);
        send_frame(16'd60, ETHERTYPE_IPV4, PROTO_TCP, dest_pool[6], 64'd5);
        send_frame(TCP_END_BYTES - 16'd1, ETHERTYPE_IPV4, PROTO_TCP, dest_pool[6], HOLD_RESET);
        send_frame(16'd60, ETHERTYPE_IPV4, 8'd1, dest_pool[1], HOLD_MAX);
        send_frame(IP_END_BYTES, ETHERTYPE_IPV4, 8'h00, dest_pool[0], 64'd0);
    endtask

    task automatic test_zero_hold();
        load_settings(64'd0, 16'd0, 16'hFFFF);
        send_batch(75, 64'd0, 5, 0);
        send_batch(75, 64'd1, 5, 0);
    endtask

    task automatic test_max_hold();
        load_settings(HOLD_MAX, 16'hFFFF, 16'd0);
        send_batch(100, 64'hFFFF_FFFF, 20, 0);
    endtask

    task automatic test_short_hold();
        logic [63:0] hold;
        hold = 64'($urandom_range(200, 2000));
        load_settings(hold, 16'($urandom), 16'($urandom));
        clock_ns = HOLD_MAX - 64'd5000;
        send_batch(350, hold / 20, 3, 0);
        drain_results();
        send_batch(350, hold / 20, 3, 0);
    endtask

    task automatic test_wide_hold();
        load_settings({$urandom, $urandom}, 16'($urandom), 16'($urandom));
        send_batch(300, 64'h3FFF, 60, 0);
    endtask

    // Half the frames bring new destinations until the table overflows.
    task automatic test_table_full();
        load_settings(64'd100, 16'($urandom), 16'($urandom));
        send_batch(300, 64'd5, 3, 50);
    endtask

    task automatic check_verdict(input t_verdict got);
        t_verdict want;
        if (expected_verdicts.size() == 0) begin
            $error("result with none outstanding: %h", got);
            errors++;
            return;
        end
        want = expected_verdicts.pop_front();
        if (got.verdict !== want.verdict) begin
            $error("verdict: expected %0d, got %0d", want.verdict, got.verdict);
            errors++;
        end
        if (got.rewrite_kind !== want.rewrite_kind) begin
            $error("rewrite_kind: expected %0d, got %0d", want.rewrite_kind, got.rewrite_kind);
            errors++;
        end
        if (got.table_event !== want.table_event) begin
            $error("table_event: expected %0d, got %0d", want.table_event, got.table_event);
            errors++;
        end
        if (got.pad !== want.pad) begin
            $error("pad: expected %0d, got %0d", want.pad, got.pad);
            errors++;
        end
    endtask

    initial begin : result_sink
        int stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = sink_idling ? $urandom_range(0, 14) : 0;
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
            check_verdict(o_m_axis_tdata);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin : test_sequence
        bit clash;
        for (int i = 0; i < TABLE_ENTRIES_DEF; i++)
            dest_used[i] = 1'b0;
        dest_pool[0] = 32'h0000_0000;
        dest_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++) begin
            do begin
                dest_pool[i] = $urandom;
                clash = 1'b0;
                for (int j = 0; j < i; j++)
                    if (dest_pool[j] == dest_pool[i])
                        clash = 1'b1;
            end while (clash);
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_zero_hold();
        test_max_hold();
        test_short_hold();
        test_wide_hold();
        test_table_full();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
